### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/idv_pkg.sv
`timescale 1ns / 1ps
package idv_pkg;

   localparam int unsigned ID_LEN   = 18;
   localparam int unsigned BODY_LEN = 17;
   localparam int unsigned POS_W    = 5;

   typedef enum logic [1:0] {
      FAIL_NONE   = 2'd0,
      FAIL_FORMAT = 2'd1,
      FAIL_CHECK  = 2'd2
   } fail_reason_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [3:0]       sum;
      logic             fmt_ok;
      logic [3:0]       prev;
   } idv_state_type;

   typedef struct packed {
      logic            fire;
      logic            is_valid;
      fail_reason_type reason;
   } idv_result_type;

   localparam idv_state_type STATE_RESET = '{pos: '0, sum: 4'd0, fmt_ok: 1'b1, prev: 4'd0};

endpackage

### rtl/id_number_check_digit_validator_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Identity-number check-digit validator (18 characters, weighted sum mod 11).
// req channel: one ASCII character per beat in req_tdata, req_tlast on the
// final character. Every beat is checked against the format of its position;
// each digit of the first 17 is folded into the weighted sum in the same cycle.
// rsp channel: one beat per string, issued for the beat that carried
// req_tlast: rsp_tdata[0] is_valid, rsp_tdata[2:1] fail reason
// (0 ok, 1 format or length error, 2 check character mismatch).
// Throughput: one character per cycle while req_tready is high; registers hold
// the scan state (position, sum mod 11, format flag, last digit) and the result.
// Latency: the result beat is valid the cycle after the last character.
// When the receiver stalls, the result waits in the output register;
// characters still flow in while it is taken, and req_tready drops only
// when a result is held and rsp_tready is low.
// Reset (synchronous, active high) clears the output valid flag and returns
// the scan state to the start of a string.
module id_number_check_digit_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] is_valid, [2:1] fail_reason, [7:3] zero
);
   import idv_pkg::*;

   idv_state_type  state_ff;
   idv_state_type  state_in;
   idv_state_type  state_step;
   idv_result_type result;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [2:0]     rsp_data_ff;
   logic [2:0]     rsp_data_in;
   logic           req_beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   idv_step u_step (
      .state_cur     (state_ff),
      .char_in       (req_tdata),
      .end_of_string (req_tlast),
      .state_nxt     (state_step),
      .result        (result)
   );

   always_comb begin
      state_in     = req_beat ? state_step : state_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_beat && result.fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {result.reason, result.is_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   `ASSERT_CLK(a_last_gives_rsp, clock, reset,
      (req_beat && req_tlast) |=> rsp_tvalid, "last beat produced no result")
   `ASSERT_CLK(a_last_clears_pos, clock, reset,
      (req_beat && req_tlast) |=> (state_ff.pos == '0), "position not cleared after last beat")
   `ASSERT_CLK(a_valid_matches_reason, clock, reset,
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == FAIL_NONE)),
      "is_valid disagrees with fail reason")
   // state is unknown until the first reset edge
   `ASSERT_ALWAYS(a_pos_bound, clock,
      reset || (state_ff.pos <= POS_W'(ID_LEN)), "position beyond string length")

endmodule

### rtl/idv_step.sv
`timescale 1ns / 1ps
module idv_step (
   input  idv_pkg::idv_state_type  state_cur,
   input  logic [7:0]              char_in,
   input  logic                    end_of_string,
   output idv_pkg::idv_state_type  state_nxt,
   output idv_pkg::idv_result_type result
);
   import idv_pkg::*;

   function automatic logic [3:0] weight_of(input logic [POS_W-1:0] p);
      logic [3:0] w;
      unique case (p)
         5'd0, 5'd10:  w = 4'd7;
         5'd1, 5'd11:  w = 4'd9;
         5'd2, 5'd12:  w = 4'd10;
         5'd3, 5'd13:  w = 4'd5;
         5'd4, 5'd14:  w = 4'd8;
         5'd5, 5'd15:  w = 4'd4;
         5'd6, 5'd16:  w = 4'd2;
         5'd7:         w = 4'd1;
         5'd8:         w = 4'd6;
         5'd9:         w = 4'd3;
         default:      w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] check_char(input logic [3:0] s);
      logic [7:0] c;
      unique case (s)
         4'd0:    c = "1";
         4'd1:    c = "0";
         4'd2:    c = "X";
         4'd3:    c = "9";
         4'd4:    c = "8";
         4'd5:    c = "7";
         4'd6:    c = "6";
         4'd7:    c = "5";
         4'd8:    c = "4";
         4'd9:    c = "3";
         4'd10:   c = "2";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Reduce a value below 101 mod 11 by conditional subtraction.
   function automatic logic [3:0] mod11(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd88) r = r - 7'd88;
      if (r >= 7'd44) r = r - 7'd44;
      if (r >= 7'd22) r = r - 7'd22;
      if (r >= 7'd11) r = r - 7'd11;
      return r[3:0];
   endfunction

   // Position rules of the format; d is this digit, p the digit before it.
   function automatic logic digit_fits(input logic [POS_W-1:0] p_pos,
                                       input logic [3:0] d, input logic [3:0] p);
      logic ok;
      unique case (p_pos)
         5'd0:    ok = (d >= 4'd1) && (d <= 4'd6);
         5'd1:    ok = (p == 4'd5) || (d >= 4'd1);
         5'd6:    ok = (d == 4'd1) || (d == 4'd2);
         5'd7:    ok = ((p == 4'd1) && ((d == 4'd8) || (d == 4'd9))) ||
                       ((p == 4'd2) && (d == 4'd0));
         5'd10:   ok = d <= 4'd1;
         5'd11:   ok = ((p == 4'd0) && (d >= 4'd1)) || ((p == 4'd1) && (d <= 4'd2));
         5'd12:   ok = d <= 4'd3;
         5'd13:   ok = ((p == 4'd0) && (d >= 4'd1)) || (p == 4'd1) || (p == 4'd2) ||
                       ((p == 4'd3) && (d <= 4'd1));
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   logic          is_digit;
   logic [3:0]    digit;
   logic [6:0]    product;
   logic [6:0]    sum_ext;
   logic          valid_len;
   logic          check_match;
   idv_state_type upd;

   assign is_digit = (char_in >= "0") && (char_in <= "9");
   assign digit    = is_digit ? char_in[3:0] : 4'd0;
   // at most 9 * 10, fits in seven bits
   assign product  = digit * weight_of(state_cur.pos);
   assign sum_ext  = {3'd0, state_cur.sum} + product;

   always_comb begin
      upd         = state_cur;
      valid_len   = 1'b0;
      check_match = 1'b0;
      if (state_cur.pos < POS_W'(BODY_LEN)) begin
         if (!(is_digit && digit_fits(state_cur.pos, digit, state_cur.prev))) begin
            upd.fmt_ok = 1'b0;
         end
         if (is_digit) begin
            upd.sum  = mod11(sum_ext);
            upd.prev = digit;
         end
      end else if (state_cur.pos == POS_W'(BODY_LEN)) begin
         if (!(is_digit || char_in == "X" || char_in == "x")) begin
            upd.fmt_ok = 1'b0;
         end
         valid_len   = 1'b1;
         check_match = check_char(state_cur.sum) == char_in;
      end else begin
         upd.fmt_ok = 1'b0;
      end
      if (state_cur.pos < POS_W'(ID_LEN)) begin
         upd.pos = state_cur.pos + POS_W'(1);
      end
   end

   always_comb begin
      result.fire = end_of_string;
      if (!upd.fmt_ok || !valid_len) begin
         result.is_valid = 1'b0;
         result.reason   = FAIL_FORMAT;
      end else if (!check_match) begin
         result.is_valid = 1'b0;
         result.reason   = FAIL_CHECK;
      end else begin
         result.is_valid = 1'b1;
         result.reason   = FAIL_NONE;
      end
      state_nxt = end_of_string ? STATE_RESET : upd;
   end

endmodule
